// ----- rtl/core/two_point_radial_gradient_shader_core_defines.svh -----
// ----------------------------------------------------------------------------
// grtp assertion macros
// shared assertion forms for the radial gradient shader checkers
// ----------------------------------------------------------------------------
`ifndef TWO_POINT_RADIAL_GRADIENT_SHADER_CORE_DEFINES_SVH
`define TWO_POINT_RADIAL_GRADIENT_SHADER_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define GRTP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("grtp assertion failed");

// next-cycle implication, off during reset
`define GRTP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("grtp assertion failed");

// next-cycle implication, live through reset
`define GRTP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("grtp assertion failed");

`endif

// ----- rtl/core/grtp_pkg.sv -----
// ----------------------------------------------------------------------------
// grtp_pkg
// types, constants and helpers for the two-point radial gradient shader
// ----------------------------------------------------------------------------
package grtp_pkg;

  localparam int TABLE_SHIFT_DEFAULT = 8;
  localparam int DIV_STEPS  = 33;
  localparam int SQRT_STEPS = 32;
  localparam logic [15:0] POS_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    CFG_START_RADIUS_SQ = 3'd0,
    CFG_FOUR_A          = 3'd1,
    CFG_INV_TWO_A       = 3'd2,
    CFG_ROOT_SELECT     = 3'd3,
    CFG_TILE_MODE       = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    TILE_CLAMP  = 2'd0,
    TILE_REPEAT = 2'd1,
    TILE_MIRROR = 2'd2
  } tile_mode_t;

  // word carried through the divide / square root stages
  typedef struct packed {
    logic        op;
    logic [7:0]  idx;
    logic [31:0] color;
    logic        lin;
    logic        bz;
    logic        c_neg;
    logic        c_pos;
    logic        lin_neg;
    logic        big;
    logic [31:0] b;
    logic [31:0] dd;
    logic [32:0] drem;
    logic [32:0] dnum;
    logic [32:0] quo;
    logic [63:0] sv;
    logic [33:0] srem;
    logic [31:0] root;
  } grtp_iter_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // signed 32-bit value from sign and magnitude, saturated
  function automatic logic [31:0] sat32(input logic neg, input logic [48:0] m);
    if (neg) begin
      return (m > 49'h0_8000_0000) ? 32'h8000_0000 : (~m[31:0] + 32'd1);
    end
    return (m > 49'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
  endfunction

endpackage

// ----- rtl/core/grtp_front.sv -----
// ----------------------------------------------------------------------------
// grtp_front
// squares, c term, 4ac product and discriminant; sets up divide and root
// ----------------------------------------------------------------------------
module grtp_front import grtp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_vld,
  input  logic        operation,
  input  logic [31:0] coord_x,
  input  logic [31:0] coord_y,
  input  logic [31:0] b_term,
  input  logic [7:0]  entry_index,
  input  logic [31:0] entry_color,
  input  logic [30:0] start_radius_sq,
  input  logic [31:0] four_a,
  output logic        out_vld,
  output grtp_iter_t  out_d
);

  // stage 1: input capture
  logic        v1, op1;
  logic [31:0] x1, y1, b1, col1;
  logic [7:0]  idx1;
  // stage 2: squares
  logic        v2, op2;
  logic [47:0] xx2, yy2, bb2;
  logic [31:0] b2, col2;
  logic [7:0]  idx2;
  // stage 3: c
  logic        v3, op3;
  logic [31:0] c3, b3, col3;
  logic [47:0] bb3;
  logic [7:0]  idx3;
  // stage 4: 4ac and divide setup
  logic        v4;
  grtp_iter_t  d4;
  logic [47:0] bb4, facm4;
  logic        facn4;

  logic [63:0] px, py, pb, pf;
  logic [49:0] sum3, summ3, disc5, dmag5;
  logic [31:0] cmag, bmag;
  grtp_iter_t  d5;

  always_comb begin
    px    = mag32(x1) * mag32(x1);
    py    = mag32(y1) * mag32(y1);
    pb    = mag32(b1) * mag32(b1);
    sum3  = {2'b0, xx2} + {2'b0, yy2} - {19'b0, start_radius_sq};
    summ3 = sum3[49] ? (~sum3 + 50'd1) : sum3;
    cmag  = mag32(c3);
    bmag  = mag32(b3);
    pf    = mag32(four_a) * cmag;
    disc5 = {2'b0, bb4} - (facn4 ? (~{2'b0, facm4} + 50'd1) : {2'b0, facm4});
    dmag5 = disc5[49] ? (~disc5 + 50'd1) : disc5;
    d5    = d4;
    d5.sv = {dmag5[47:0], 16'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_vld <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1  <= operation;
      x1   <= coord_x;
      y1   <= coord_y;
      b1   <= b_term;
      idx1 <= entry_index;
      col1 <= entry_color;

      op2  <= op1;
      xx2  <= px[63:16];
      yy2  <= py[63:16];
      bb2  <= pb[63:16];
      b2   <= b1;
      idx2 <= idx1;
      col2 <= col1;

      op3  <= op2;
      c3   <= sat32(sum3[49], summ3[48:0]);
      bb3  <= bb2;
      b3   <= b2;
      idx3 <= idx2;
      col3 <= col2;

      d4.op      <= op3;
      d4.idx     <= idx3;
      d4.color   <= col3;
      d4.lin     <= (four_a == 32'd0);
      d4.bz      <= (b3 == 32'd0);
      d4.c_neg   <= c3[31];
      d4.c_pos   <= !c3[31] && (c3 != 32'd0);
      d4.lin_neg <= (!c3[31] && (c3 != 32'd0)) ^ b3[31];
      // quotient of 2^33 or more always saturates
      d4.big     <= ({17'b0, cmag[31:17]} >= bmag);
      d4.b       <= b3;
      d4.dd      <= bmag;
      d4.drem    <= {18'b0, cmag[31:17]};
      d4.dnum    <= {cmag[16:0], 16'b0};
      d4.quo     <= '0;
      d4.sv      <= '0;
      d4.srem    <= '0;
      d4.root    <= '0;
      bb4        <= bb3;
      facm4      <= pf[63:16];
      facn4      <= four_a[31] ^ c3[31];

      out_d      <= d5;
    end
  end

endmodule

// ----- rtl/core/grtp_iter_stage.sv -----
// ----------------------------------------------------------------------------
// grtp_iter_stage
// one restoring divide bit and, when SQRT_EN is set, one square root bit per stage
// ----------------------------------------------------------------------------
module grtp_iter_stage import grtp_pkg::*; #(
  parameter bit SQRT_EN = 1'b1
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_vld,
  input  grtp_iter_t in_d,
  output logic       out_vld,
  output grtp_iter_t out_d
);

  logic [32:0] dr2;
  logic        dge;
  logic [35:0] sr2, trial;
  logic        sge;
  grtp_iter_t  nxt;

  always_comb begin
    nxt   = in_d;
    dr2   = {in_d.drem[31:0], in_d.dnum[32]};
    dge   = (dr2 >= {1'b0, in_d.dd});
    nxt.drem = dge ? (dr2 - {1'b0, in_d.dd}) : dr2;
    nxt.dnum = {in_d.dnum[31:0], 1'b0};
    nxt.quo  = {in_d.quo[31:0], dge};
    sr2   = {in_d.srem, in_d.sv[63:62]};
    trial = {2'b0, in_d.root, 2'b01};
    sge   = (sr2 >= trial);
    if (SQRT_EN) begin
      nxt.srem = sge ? 34'(sr2 - trial) : sr2[33:0];
      nxt.root = {in_d.root[30:0], sge};
      nxt.sv   = {in_d.sv[61:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d <= nxt;
    end
  end

endmodule

// ----- rtl/core/grtp_back.sv -----
// ----------------------------------------------------------------------------
// grtp_back
// root selection, 1/(2a) scaling, tiling and colour table
// ----------------------------------------------------------------------------
module grtp_back import grtp_pkg::*; #(
  parameter int TABLE_SHIFT = TABLE_SHIFT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_vld,
  input  grtp_iter_t  in_d,
  input  logic [31:0] inv_two_a,
  input  logic        root_select,
  input  logic [1:0]  tile_mode,
  output logic        out_vld,
  output logic [31:0] pixel_color,
  output logic [15:0] gradient_pos
);

  logic        v1, v2, v3;
  logic        op1, op2, op3, lin1;
  logic [7:0]  idx1, idx2, idx3;
  logic [31:0] col1, col2, col3, tl1, t2;
  logic [32:0] smag1;
  logic        sneg1;
  logic [15:0] pos3;

  logic [31:0] color_table [256];

  logic [34:0] bext, rext, s;
  logic [31:0] tl;
  logic [64:0] prod;
  logic [15:0] pos;
  logic [7:0]  addr;

  always_comb begin
    bext = {{3{in_d.b[31]}}, in_d.b};
    rext = {3'b0, in_d.root};
    s    = root_select ? (rext - bext) : (35'd0 - bext - rext);
    if (in_d.bz) begin
      tl = in_d.c_neg ? 32'h7FFF_FFFF : (in_d.c_pos ? 32'h8000_0000 : 32'd0);
    end else if (in_d.big) begin
      tl = in_d.lin_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      tl = sat32(in_d.lin_neg, {16'b0, in_d.quo});
    end
    prod = smag1 * mag32(inv_two_a);
    case (tile_mode)
      TILE_CLAMP: begin
        if (t2[31]) begin
          pos = 16'd0;
        end else if (|t2[30:16]) begin
          pos = POS_MAX;
        end else begin
          pos = t2[15:0];
        end
      end
      TILE_MIRROR: pos = t2[16] ? ~t2[15:0] : t2[15:0];
      default:     pos = t2[15:0];
    endcase
    addr = 8'(pos3 >> TABLE_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
      out_vld <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1   <= in_d.op;
      idx1  <= in_d.idx;
      col1  <= in_d.color;
      lin1  <= in_d.lin;
      tl1   <= tl;
      sneg1 <= s[34];
      smag1 <= s[34] ? 33'(35'd0 - s) : s[32:0];

      op2  <= op1;
      idx2 <= idx1;
      col2 <= col1;
      t2   <= lin1 ? tl1 : sat32(sneg1 ^ inv_two_a[31], prod[64:16]);

      op3  <= op2;
      idx3 <= idx2;
      col3 <= col2;
      pos3 <= pos;

      // table writes and reads share this stage, so program order holds
      if (v3 && op3) begin
        color_table[idx3] <= col3;
      end
      pixel_color  <= op3 ? 32'd0 : color_table[addr];
      gradient_pos <= op3 ? 16'd0 : pos3;
    end
  end

endmodule

// ----- rtl/core/two_point_radial_gradient_shader_core.sv -----
// ----------------------------------------------------------------------------
// two_point_radial_gradient_shader_core
// per-pixel two-point radial gradient: solve for t, tile, colour lookup
// ----------------------------------------------------------------------------
// Takes one word per clock while in_stall is low and returns one word per
// accepted word, in order. The restoring divider retires one bit per stage
// over 33 stages, the square root one bit in each but the last; there are
// also five front stages for the squares, c and 4ac, and four back stages
// for root selection, 1/(2a) scaling, tiling and the colour table read. A
// stalled output holds the whole pipeline; in_stall follows it.
// Colour table writes travel the same pipeline and take effect in order.
module two_point_radial_gradient_shader_core import grtp_pkg::*; #(
  parameter int TABLE_SHIFT = TABLE_SHIFT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [31:0] coord_x,
  input  logic [31:0] coord_y,
  input  logic [31:0] b_term,
  input  logic [7:0]  entry_index,
  input  logic [31:0] entry_color,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] pixel_color,
  output logic [15:0] gradient_pos
);

  logic [30:0] start_radius_sq;
  logic [31:0] four_a, inv_two_a;
  logic        root_select;
  logic [1:0]  tile_mode;
  logic        en;

  logic       it_v [DIV_STEPS+1];
  grtp_iter_t it_d [DIV_STEPS+1];

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_radius_sq <= '0;
      four_a          <= '0;
      inv_two_a       <= '0;
      root_select     <= 1'b0;
      tile_mode       <= TILE_CLAMP;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_RADIUS_SQ: start_radius_sq <= cfg_data[30:0];
        CFG_FOUR_A:          four_a          <= cfg_data;
        CFG_INV_TWO_A:       inv_two_a       <= cfg_data;
        CFG_ROOT_SELECT:     root_select     <= cfg_data[0];
        CFG_TILE_MODE:       tile_mode       <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  grtp_front u_front (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .in_vld          (in_valid),
    .operation       (operation),
    .coord_x         (coord_x),
    .coord_y         (coord_y),
    .b_term          (b_term),
    .entry_index     (entry_index),
    .entry_color     (entry_color),
    .start_radius_sq (start_radius_sq),
    .four_a          (four_a),
    .out_vld         (it_v[0]),
    .out_d           (it_d[0])
  );

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_iter
    grtp_iter_stage #(
      .SQRT_EN (k < SQRT_STEPS)
    ) u_stage (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_vld  (it_v[k]),
      .in_d    (it_d[k]),
      .out_vld (it_v[k+1]),
      .out_d   (it_d[k+1])
    );
  end

  grtp_back #(
    .TABLE_SHIFT (TABLE_SHIFT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_vld       (it_v[DIV_STEPS]),
    .in_d         (it_d[DIV_STEPS]),
    .inv_two_a    (inv_two_a),
    .root_select  (root_select),
    .tile_mode    (tile_mode),
    .out_vld      (out_valid),
    .pixel_color  (pixel_color),
    .gradient_pos (gradient_pos)
  );

endmodule

// ----- rtl/core/grtp_checker.sv -----
// ----------------------------------------------------------------------------
// grtp_checker
// port-level checks for the radial gradient shader core
// ----------------------------------------------------------------------------
`include "two_point_radial_gradient_shader_core_defines.svh"

module grtp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] pixel_color,
  input logic [15:0] gradient_pos
);

  // a held result keeps its word
  `GRTP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(pixel_color) && $stable(gradient_pos))
  // input is held back only while the output is blocked
  `GRTP_ASSERT_NOW(a_stall_cause, clk, rst, in_stall, out_valid && out_stall)
  // a blocked output always holds the input
  `GRTP_ASSERT_NOW(a_stall_prop, clk, rst, out_valid && out_stall, in_stall)
  // pipeline empties on reset
  `GRTP_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid)

endmodule

bind two_point_radial_gradient_shader_core grtp_checker u_grtp_checker (.*);
